[rtl/page_bitmap_allocator_defines.svh]
// ----------------------------------------------------------------------------
// page bitmap allocator assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define PBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// types, constants and helper functions of the page bitmap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

    localparam int MAP_WORDS     = 1024;
    localparam int BITS_PER_WORD = 32;
    localparam int BIT_W         = $clog2(BITS_PER_WORD);
    localparam int MAP_AW        = $clog2(MAP_WORDS);
    localparam int PAGE_W        = MAP_AW + BIT_W;
    localparam int PAGE_SHIFT    = 12;
    localparam int ADDR_W        = 32;
    localparam int PG_NUM_W      = ADDR_W + 1 - PAGE_SHIFT;
    localparam int WSEL_W        = PG_NUM_W - BIT_W;
    localparam int CFG_W         = 20;
    localparam int CFG_IDX_W     = 1;
    localparam int OP_W          = 3;

    localparam int LOW_START_PAGE    = 'h00;
    localparam int NORMAL_START_PAGE = 'h100;

    localparam logic [BITS_PER_WORD-1:0] WORD_ONES = {BITS_PER_WORD{1'b1}};
    localparam logic [MAP_AW-1:0] LAST_WORD = MAP_AW'(MAP_WORDS - 1);
    localparam logic [MAP_AW-1:0] LOW_START_WORD =
        MAP_AW'(LOW_START_PAGE / BITS_PER_WORD);
    localparam logic [MAP_AW-1:0] NORMAL_START_WORD =
        MAP_AW'(NORMAL_START_PAGE / BITS_PER_WORD);

    localparam logic [CFG_IDX_W-1:0] CFG_PROT_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_LAST  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_LOW    = 3'd0,
        OP_ALLOC_NORMAL = 3'd1,
        OP_FREE_PAGE    = 3'd2,
        OP_FREE_REGION  = 3'd3,
        OP_LOCK_REGION  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_MOD
    } t_state;

    // control from the sequencer to the word update unit
    typedef struct packed {
        logic                is_alloc;
        logic                is_lock;
        logic [MAP_AW-1:0]   word;
        logic [PG_NUM_W-1:0] lo;
        logic [PG_NUM_W-1:0] hi;
        logic [CFG_W-1:0]    prot_first;
        logic [CFG_W-1:0]    prot_last;
    } t_upd_ctrl;

    typedef struct packed {
        logic [BITS_PER_WORD-1:0] wdata;
        logic                     full;
        logic [BIT_W-1:0]         bit_idx;
    } t_upd_res;

    // bits of word w whose page p satisfies lo <= p <= hi
    function automatic logic [BITS_PER_WORD-1:0] range_mask(
        input logic [MAP_AW-1:0]   w,
        input logic [PG_NUM_W-1:0] lo,
        input logic [PG_NUM_W-1:0] hi
    );
        logic [WSEL_W-1:0]        ww;
        logic [BITS_PER_WORD-1:0] ge;
        logic [BITS_PER_WORD-1:0] le;
        ww = {{(WSEL_W - MAP_AW){1'b0}}, w};
        if (lo[PG_NUM_W-1:BIT_W] < ww) begin
            ge = WORD_ONES;
        end else if (lo[PG_NUM_W-1:BIT_W] == ww) begin
            ge = WORD_ONES << lo[BIT_W-1:0];
        end else begin
            ge = '0;
        end
        if (hi[PG_NUM_W-1:BIT_W] > ww) begin
            le = WORD_ONES;
        end else if (hi[PG_NUM_W-1:BIT_W] == ww) begin
            le = WORD_ONES >> (BIT_W'(BITS_PER_WORD - 1) - hi[BIT_W-1:0]);
        end else begin
            le = '0;
        end
        return ge & le;
    endfunction

    // index of the lowest clear bit, top index when none is clear
    function automatic logic [BIT_W-1:0] lowest_zero(
        input logic [BITS_PER_WORD-1:0] word
    );
        logic [BIT_W-1:0] idx;
        idx = BIT_W'(BITS_PER_WORD - 1);
        for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
            if (!word[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[rtl/pba_ram.sv]
// ----------------------------------------------------------------------------
// pba_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/pba_word_update.sv]
// ----------------------------------------------------------------------------
// pba_word_update
// modify step of one bitmap word: alloc bit pick, region free and lock masks
// ----------------------------------------------------------------------------
`default_nettype none

module pba_word_update
    import pba_pkg::*;
(
    input  wire t_upd_ctrl                      i_ctrl,
    input  wire logic [BITS_PER_WORD-1:0]       i_rdata,
    output t_upd_res                            o_res
);

    logic [BITS_PER_WORD-1:0] range_bits;
    logic [BITS_PER_WORD-1:0] win_bits;
    logic [BIT_W-1:0]         free_idx;

    always_comb begin
        range_bits = range_mask(i_ctrl.word, i_ctrl.lo, i_ctrl.hi);
        win_bits   = range_mask(i_ctrl.word, {1'b0, i_ctrl.prot_first},
                                {1'b0, i_ctrl.prot_last});
        free_idx   = lowest_zero(i_rdata);

        o_res.full    = (i_rdata == WORD_ONES);
        o_res.bit_idx = free_idx;
        if (i_ctrl.is_alloc) begin
            o_res.wdata = i_rdata | (BITS_PER_WORD'(1) << free_idx);
        end else if (i_ctrl.is_lock) begin
            o_res.wdata = i_rdata | range_bits;
        end else begin
            // protected window pages are never released
            o_res.wdata = i_rdata & ~(range_bits & ~win_bits);
        end
    end

endmodule

`default_nettype wire

[rtl/page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// 4 KiB page frame allocator over a bitmap ram, one locked bit per page
// ----------------------------------------------------------------------------
// reset: a clearing pass over all MAP_WORDS words (1024) sets every word to all ones;
//   busy stays high meanwhile, config writes are taken at any time
// each word touched goes through a ram read, then a modify and write back
// alloc: scans words upward from its start word until one has a clear bit or the map ends
// free / lock: walks every word of the region; empty, past the map or unused: result straight from setup
// one transaction at a time; the receiver cannot stall, o_done lasts 1 cycle
`default_nettype none

module page_bitmap_allocator
    import pba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      i_opcode,
    input  wire logic [ADDR_W-1:0]    i_byte_address,
    input  wire logic [ADDR_W-1:0]    i_byte_count,
    // result channel
    output logic                      o_done,
    output logic [ADDR_W-1:0]         o_page_address,
    output logic                      o_alloc_failed,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    // sequencer state and the transaction being worked on
    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [PAGE_W-PAGE_W+CFG_W-1:0] r_first, n_first;   // byte_address page
    logic                r_cnt_zero, n_cnt_zero;
    logic [ADDR_W:0]     r_sum, n_sum;                   // address + count, no wrap
    logic [PG_NUM_W-1:0] r_lo, n_lo;
    logic [PG_NUM_W-1:0] r_hi, n_hi;
    logic [MAP_AW-1:0]   r_w, n_w;                       // current word
    logic [MAP_AW-1:0]   r_last_w, n_last_w;             // last word of a region

    // result registers
    logic                r_done, n_done;
    logic [ADDR_W-1:0]   r_page_address, n_page_address;
    logic                r_alloc_failed, n_alloc_failed;

    // protected window
    logic [CFG_W-1:0]    r_prot_first;
    logic [CFG_W-1:0]    r_prot_last;

    // ram side
    logic                     ram_we;
    logic [BITS_PER_WORD-1:0] ram_wdata;
    logic                     ram_re;
    logic [BITS_PER_WORD-1:0] ram_rdata;

    t_upd_ctrl upd_ctrl;
    t_upd_res  upd_res;

    // region bounds worked out in setup
    logic [ADDR_W:0]     sum_m1;
    logic [PG_NUM_W-1:0] end_excl;
    logic [PG_NUM_W-1:0] lock_hi;
    logic [PG_NUM_W-1:0] setup_lo;
    logic [PG_NUM_W-1:0] setup_hi;
    logic                setup_nonempty;
    logic                setup_walk;
    logic [ADDR_W-1:0]   alloc_addr;

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_page_address = r_page_address;
    assign o_alloc_failed = r_alloc_failed;

    // bitmap storage; reads and writes of the same word never overlap because
    // the sequencer reads a word only after the previous write has landed
    pba_ram #(
        .WIDTH (BITS_PER_WORD),
        .DEPTH (MAP_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_w),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_w),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        upd_ctrl.is_alloc   = (r_op == OP_ALLOC_LOW) || (r_op == OP_ALLOC_NORMAL);
        upd_ctrl.is_lock    = (r_op == OP_LOCK_REGION);
        upd_ctrl.word       = r_w;
        upd_ctrl.lo         = r_lo;
        upd_ctrl.hi         = r_hi;
        upd_ctrl.prot_first = r_prot_first;
        upd_ctrl.prot_last  = r_prot_last;
    end

    pba_word_update u_update (
        .i_ctrl  (upd_ctrl),
        .i_rdata (ram_rdata),
        .o_res   (upd_res)
    );

    // region bounds in page numbers
    always_comb begin
        sum_m1   = r_sum - (ADDR_W + 1)'(1);
        end_excl = r_sum[ADDR_W:PAGE_SHIFT];
        lock_hi  = r_cnt_zero ? {1'b0, r_first} : sum_m1[ADDR_W:PAGE_SHIFT];
        setup_lo = {1'b0, r_first};
        case (r_op)
            OP_FREE_REGION: begin
                setup_hi       = end_excl - PG_NUM_W'(1);
                setup_nonempty = (end_excl > setup_lo);
            end
            OP_LOCK_REGION: begin
                setup_hi       = lock_hi;
                setup_nonempty = 1'b1;
            end
            default: begin
                // single page free
                setup_hi       = setup_lo;
                setup_nonempty = 1'b1;
            end
        endcase
        // regions starting past the end of the map touch nothing
        setup_walk = setup_nonempty && (setup_lo[PG_NUM_W-1:PAGE_W] == '0);

        alloc_addr = '0;
        alloc_addr[PAGE_SHIFT +: PAGE_W] = {r_w, upd_res.bit_idx};
    end

    // sequencer: next state, ram controls, result registers
    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_first        = r_first;
        n_cnt_zero     = r_cnt_zero;
        n_sum          = r_sum;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_w            = r_w;
        n_last_w       = r_last_w;
        n_done         = 1'b0;
        n_page_address = r_page_address;
        n_alloc_failed = r_alloc_failed;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = upd_res.wdata;

        unique case (r_state)
            S_CLEAR: begin
                // sweep every word to all ones, i.e. every page locked
                ram_we    = 1'b1;
                ram_wdata = WORD_ONES;
                if (r_w == LAST_WORD) begin
                    n_w     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_w = r_w + MAP_AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op       = t_op'(i_opcode);
                    n_first    = i_byte_address[ADDR_W-1:PAGE_SHIFT];
                    n_cnt_zero = (i_byte_count == '0);
                    n_sum      = {1'b0, i_byte_address} + {1'b0, i_byte_count};
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                case (r_op)
                    OP_ALLOC_LOW: begin
                        n_w     = LOW_START_WORD;
                        n_state = S_RD;
                    end
                    OP_ALLOC_NORMAL: begin
                        n_w     = NORMAL_START_WORD;
                        n_state = S_RD;
                    end
                    OP_FREE_PAGE, OP_FREE_REGION, OP_LOCK_REGION: begin
                        if (setup_walk) begin
                            n_lo     = setup_lo;
                            n_hi     = setup_hi;
                            n_w      = setup_lo[PAGE_W-1:BIT_W];
                            // clamp the walk to the last word of the map
                            n_last_w = (setup_hi[PG_NUM_W-1:PAGE_W] != '0)
                                       ? LAST_WORD : setup_hi[PAGE_W-1:BIT_W];
                            n_state  = S_RD;
                        end else begin
                            n_done         = 1'b1;
                            n_page_address = '0;
                            n_alloc_failed = 1'b0;
                            n_state        = S_IDLE;
                        end
                    end
                    default: begin
                        // unused opcode: no change, zero result
                        n_done         = 1'b1;
                        n_page_address = '0;
                        n_alloc_failed = 1'b0;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (upd_ctrl.is_alloc) begin
                    if (!upd_res.full) begin
                        // lowest clear bit taken, word written back
                        ram_we         = 1'b1;
                        n_done         = 1'b1;
                        n_page_address = alloc_addr;
                        n_alloc_failed = 1'b0;
                        n_state        = S_IDLE;
                    end else if (r_w == LAST_WORD) begin
                        n_done         = 1'b1;
                        n_page_address = '0;
                        n_alloc_failed = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_w     = r_w + MAP_AW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    ram_we = 1'b1;
                    if (r_w == r_last_w) begin
                        n_done         = 1'b1;
                        n_page_address = '0;
                        n_alloc_failed = 1'b0;
                        n_state        = S_IDLE;
                    end else begin
                        n_w     = r_w + MAP_AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_w        <= '0;
            r_done     <= 1'b0;
            r_op       <= OP_ALLOC_LOW;
        end else begin
            r_state    <= n_state;
            r_w        <= n_w;
            r_done     <= n_done;
            r_op       <= n_op;
        end
    end

    // transaction payload and result data need no reset
    always_ff @(posedge i_clk) begin
        r_first        <= n_first;
        r_cnt_zero     <= n_cnt_zero;
        r_sum          <= n_sum;
        r_lo           <= n_lo;
        r_hi           <= n_hi;
        r_last_w       <= n_last_w;
        r_page_address <= n_page_address;
        r_alloc_failed <= n_alloc_failed;
    end

    // protected window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prot_first <= '0;
            r_prot_last  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROT_FIRST: r_prot_first <= i_cfg_wdata;
                CFG_PROT_LAST:  r_prot_last  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/pba_checker.sv]
// ----------------------------------------------------------------------------
// pba_checker
// port-level assertions of the page bitmap allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_bitmap_allocator_defines.svh"

module pba_checker
    import pba_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              i_busy,
    input wire logic              i_done,
    input wire logic [ADDR_W-1:0] i_page_address,
    input wire logic              i_alloc_failed
);

    // an accepted transaction always raises busy in the cycle after it is taken
    `PBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy, "accepted transaction did not raise busy")

    // a result is only shown once the block is free again
    `PBA_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, i_done, !i_busy, "result strobe while busy")

    // strobes are single cycle pulses
    `PBA_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, i_done, !i_done, "result strobe longer than one cycle")

    // a failed allocation reports address zero
    `PBA_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, i_done && i_alloc_failed, i_page_address == '0, "failed allocation with nonzero address")

    // returned addresses are page aligned
    `PBA_ASSERT_SAME(a_page_align, i_clk, i_rst_n, i_done, i_page_address[PAGE_SHIFT-1:0] == '0, "unaligned page address")

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_done         (o_done),
    .i_page_address (o_page_address),
    .i_alloc_failed (o_alloc_failed)
);

`default_nettype wire

[tb/page_bitmap_allocator_check.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator_check
// watches the command, result and register ports, keeps its own page map and
// compares every result strobe with the oldest predicted request outcome
// ----------------------------------------------------------------------------
module page_bitmap_allocator_check
    import pba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [ADDR_W-1:0]    i_byte_address,
    input  logic [ADDR_W-1:0]    i_byte_count,
    input  logic                 i_done,
    input  logic [ADDR_W-1:0]    i_page_address,
    input  logic                 i_alloc_failed,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MAP_PAGES = MAP_WORDS * BITS_PER_WORD;
    localparam int              PRINT_CAP = 200;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              alloc_failed;
    } t_page_result;

    logic [BITS_PER_WORD-1:0] page_map [MAP_WORDS];
    logic [CFG_W-1:0]         guard_first;
    logic [CFG_W-1:0]         guard_last;
    t_page_result             expected_pages [$];

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                   input logic [ADDR_W-1:0] got);
        if (o_fail_count < PRINT_CAP) begin
            $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
        end
        o_fail_count++;
    endtask

    // pages of word w that fall in lo..hi inclusive
    function automatic logic [BITS_PER_WORD-1:0] pages_in_word(
        input longint unsigned w,
        input longint unsigned lo,
        input longint unsigned hi
    );
        longint unsigned base;
        longint unsigned l;
        longint unsigned h;
        base = w * BITS_PER_WORD;
        if (lo > hi || hi < base || lo > base + BITS_PER_WORD - 1) begin
            return '0;
        end
        l = (lo > base) ? lo - base : 0;
        h = (hi < base + BITS_PER_WORD - 1) ? hi - base : BITS_PER_WORD - 1;
        return ({BITS_PER_WORD{1'b1}} << l) & ({BITS_PER_WORD{1'b1}} >> (BITS_PER_WORD - 1 - h));
    endfunction

    // clear pages lo..hi, skipping the guarded window and anything past the map
    function automatic void release_pages(input longint unsigned lo, input longint unsigned hi);
        longint unsigned          w;
        logic [BITS_PER_WORD-1:0] m;
        if (hi > MAP_PAGES - 1) begin
            hi = MAP_PAGES - 1;
        end
        if (lo > hi) begin
            return;
        end
        for (w = lo / BITS_PER_WORD; w <= hi / BITS_PER_WORD; w++) begin
            m = pages_in_word(w, lo, hi);
            if (guard_first <= guard_last) begin
                m &= ~pages_in_word(w, 64'(guard_first), 64'(guard_last));
            end
            page_map[w] &= ~m;
        end
    endfunction

    function automatic void lock_pages(input longint unsigned lo, input longint unsigned hi);
        longint unsigned w;
        if (hi > MAP_PAGES - 1) begin
            hi = MAP_PAGES - 1;
        end
        if (lo > hi) begin
            return;
        end
        for (w = lo / BITS_PER_WORD; w <= hi / BITS_PER_WORD; w++) begin
            page_map[w] |= pages_in_word(w, lo, hi);
        end
    endfunction

    // first-fit scan upward from a start word
    function automatic t_page_result claim_page(input int unsigned from_word);
        t_page_result r;
        int unsigned  w;
        int unsigned  b;
        r.page_address = '0;
        r.alloc_failed = 1'b1;
        for (w = from_word; w < MAP_WORDS; w++) begin
            if (page_map[w] != {BITS_PER_WORD{1'b1}}) begin
                b = 0;
                while (page_map[w][b]) begin
                    b++;
                end
                page_map[w][b] = 1'b1;
                r.page_address = ADDR_W'((w * BITS_PER_WORD + b) << PAGE_SHIFT);
                r.alloc_failed = 1'b0;
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_page_result predict_page_request(
        input logic [OP_W-1:0]   op,
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] len
    );
        t_page_result    r;
        longint unsigned first_pg;
        longint unsigned end_pg;
        longint unsigned last_pg;
        r = '0;
        first_pg = 64'(addr) >> PAGE_SHIFT;
        case (op)
            OP_ALLOC_LOW: begin
                r = claim_page(LOW_START_PAGE / BITS_PER_WORD);
            end
            OP_ALLOC_NORMAL: begin
                r = claim_page(NORMAL_START_PAGE / BITS_PER_WORD);
            end
            OP_FREE_PAGE: begin
                release_pages(first_pg, first_pg);
            end
            OP_FREE_REGION: begin
                // end is exclusive, sum kept to 33 bits
                end_pg = ({32'b0, addr} + {32'b0, len}) >> PAGE_SHIFT;
                if (end_pg > first_pg) begin
                    release_pages(first_pg, end_pg - 1);
                end
            end
            OP_LOCK_REGION: begin
                if (len == '0) begin
                    last_pg = first_pg;
                end else begin
                    last_pg = ({32'b0, addr} + {32'b0, len} - 1) >> PAGE_SHIFT;
                end
                if (last_pg < first_pg) begin
                    last_pg = first_pg;
                end
                lock_pages(first_pg, last_pg);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_page_result want;
        if (!i_rst_n) begin
            foreach (page_map[w]) begin
                page_map[w] = {BITS_PER_WORD{1'b1}};
            end
            guard_first = '0;
            guard_last  = '0;
            expected_pages.delete();
        end else begin
            if (i_done) begin
                if (expected_pages.size() == 0) begin
                    report_mismatch("unexpected result", '0, i_page_address);
                end else begin
                    want = expected_pages.pop_front();
                    if (i_page_address !== want.page_address) begin
                        report_mismatch("page_address", want.page_address, i_page_address);
                    end
                    if (i_alloc_failed !== want.alloc_failed) begin
                        report_mismatch("alloc_failed", ADDR_W'(want.alloc_failed),
                                        ADDR_W'(i_alloc_failed));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROT_FIRST: guard_first = i_cfg_wdata;
                    CFG_PROT_LAST:  guard_last  = i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                expected_pages.push_back(
                    predict_page_request(i_opcode, i_byte_address, i_byte_count));
            end
        end
        o_pending = expected_pages.size();
    end

endmodule

[tb/page_bitmap_allocator_test.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator_test
// drives page requests and guard window settings into the allocator; a
// checker beside the block predicts every result, this module gives the verdict
// ----------------------------------------------------------------------------
module page_bitmap_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pba_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REG_SETTLE    = 4;
    localparam int HOLD_PCT      = 3;
    localparam int MAP_PAGES     = MAP_WORDS * BITS_PER_WORD;
    localparam int PAGE_BYTES    = 1 << PAGE_SHIFT;
    // most traffic lands in the first 128 words so allocations stay short
    localparam int LOW_ZONE      = 4096;

    localparam logic [CFG_W-1:0] CFG_MAX         = {CFG_W{1'b1}};
    localparam logic [OP_W-1:0]  OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0]  OP_UNUSED_LAST  = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      opcode;
    logic [ADDR_W-1:0]    byte_address;
    logic [ADDR_W-1:0]    byte_count;
    logic                 done;
    logic [ADDR_W-1:0]    page_address;
    logic                 alloc_failed;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    int pending;
    int fail_count;
    int idle_pct;
    int stall_cycles = 0;
    bit timed_out;

    always #CLK_HALF clk = ~clk;

    page_bitmap_allocator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (opcode),
        .i_byte_address (byte_address),
        .i_byte_count   (byte_count),
        .o_done         (done),
        .o_page_address (page_address),
        .o_alloc_failed (alloc_failed),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata)
    );

    page_bitmap_allocator_check u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (opcode),
        .i_byte_address (byte_address),
        .i_byte_count   (byte_count),
        .i_done         (done),
        .i_page_address (page_address),
        .i_alloc_failed (alloc_failed),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // watchdog: cycles with neither a command nor a result transaction
    always @(posedge clk) begin
        if ((start && busy === 1'b0) || done === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one command transaction; entered and left at a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [ADDR_W-1:0] len);
        // random sender gaps before the command
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        byte_address <= addr;
        byte_count   <= len;
        do @(posedge clk); while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // stop sending until every predicted result has come back
    task automatic drain_results(input int settle);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy !== 1'b0) begin
            @(negedge clk);
        end
        repeat (settle) @(negedge clk);
    endtask

    // guard window is only rewritten with the block idle
    task automatic set_guard_window(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] last);
        drain_results(REG_SETTLE);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_PROT_FIRST;
        cfg_wdata <= first;
        @(negedge clk);
        cfg_idx   <= CFG_PROT_LAST;
        cfg_wdata <= last;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_request();
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        int unsigned       roll;
        int unsigned       spread;
        spread = $urandom_range(99);
        if (spread < 75) begin
            addr = (ADDR_W'($urandom_range(LOW_ZONE - 1)) << PAGE_SHIFT)
                 | ADDR_W'($urandom_range(PAGE_BYTES - 1));
        end else if (spread < 90) begin
            addr = (ADDR_W'($urandom_range(MAP_PAGES - 1)) << PAGE_SHIFT)
                 | ADDR_W'($urandom_range(PAGE_BYTES - 1));
        end else begin
            addr = $urandom;
        end
        // region lengths: mostly a few pages, rarely the whole map or wider
        spread = $urandom_range(99);
        if (spread < 70) begin
            len = $urandom_range(8 * PAGE_BYTES);
        end else if (spread < 90) begin
            len = $urandom_range(256 * PAGE_BYTES);
        end else if (spread < 97) begin
            len = $urandom_range(MAP_PAGES * PAGE_BYTES);
        end else begin
            len = $urandom;
        end
        roll = $urandom_range(99);
        if (roll < 25) begin
            op = OP_ALLOC_LOW;
        end else if (roll < 35) begin
            op = OP_ALLOC_NORMAL;
        end else if (roll < 50) begin
            op = OP_FREE_PAGE;
        end else if (roll < 75) begin
            op = OP_FREE_REGION;
        end else if (roll < 90) begin
            op = OP_LOCK_REGION;
        end else begin
            // noise: unused opcodes with arbitrary fields
            op   = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            addr = $urandom;
            len  = $urandom;
        end
        send_request(op, addr, len);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] last,
                             input int pct, input int count);
        set_guard_window(first, last);
        idle_pct = pct;
        repeat (count) begin
            if ($urandom_range(99) < HOLD_PCT) begin
                drain_results(0);
            end
            random_request();
        end
    endtask

    initial begin
        int unsigned win_lo;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_ALLOC_LOW;
        byte_address = '0;
        byte_count   = '0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_PROT_FIRST;
        cfg_wdata    = '0;
        idle_pct     = 0;
        timed_out    = 1'b0;
        fork
            begin
                repeat (RESET_CYCLES) @(negedge clk);
                rst_n <= 1'b1;
                @(negedge clk);
                // clearing pass after reset keeps busy high
                while (busy !== 1'b0) begin
                    @(negedge clk);
                end

                // every page starts locked, page 0 is guarded by default
                send_request(OP_ALLOC_LOW, '0, '0);
                send_request(OP_ALLOC_NORMAL, '1, '1);
                send_request(OP_FREE_PAGE, 32'h0000_0FFF, '0);
                send_request(OP_UNUSED_FIRST, '1, '1);
                send_request(OP_UNUSED_LAST, 32'h0000_1000, 32'h0000_1000);
                send_request(OP_FREE_REGION, '0, 32'h0000_8000);
                send_request(OP_ALLOC_LOW, '0, '0);
                // zero length lock takes its one page
                send_request(OP_LOCK_REGION, 32'h0000_2000, '0);
                send_request(OP_ALLOC_LOW, '0, '0);
                send_request(OP_FREE_REGION, 32'h0000_0FFF, 32'h0000_0001);
                // empty free region
                send_request(OP_FREE_REGION, 32'h0000_1FFF, '0);
                // past the end of the map, region end needs 33 bits
                send_request(OP_FREE_PAGE, '1, '0);
                send_request(OP_LOCK_REGION, '1, '1);
                send_request(OP_LOCK_REGION, '0, '1);
                send_request(OP_ALLOC_NORMAL, '0, '0);
                send_request(OP_FREE_REGION, 32'h07FF_F000, 32'h0000_1000);
                drain_results(0);
                send_request(OP_ALLOC_NORMAL, '0, '0);
                send_request(OP_FREE_REGION, '0, '1);
                send_request(OP_ALLOC_NORMAL, '0, '0);

                // inverted window guards nothing, so page 0 can be handed out
                set_guard_window(CFG_MAX, '0);
                send_request(OP_FREE_PAGE, '0, '0);
                send_request(OP_ALLOC_LOW, '0, '0);
                send_request(OP_LOCK_REGION, 32'h0000_3FFF, 32'h0000_0001);
                send_request(OP_LOCK_REGION, 32'h0000_3FFF, 32'h0000_0002);

                run_phase('0, '0, 0, 300);
                // window lies wholly past the map
                run_phase(CFG_MAX, CFG_MAX, 55, 250);
                // everything guarded: frees do nothing, allocations run dry
                run_phase('0, CFG_MAX, 11, 40);
                run_phase(CFG_MAX, '0, 0, 250);
                win_lo = $urandom_range(2047);
                run_phase(CFG_W'(win_lo), CFG_W'(win_lo + $urandom_range(512)), 55, 300);
                run_phase(CFG_W'(NORMAL_START_PAGE), CFG_W'(2 * NORMAL_START_PAGE - 1), 11, 280);

                drain_results(SETTLE_CYCLES);
            end
            begin
                wait (stall_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && fail_count == 0) begin
            $display("PASS page_bitmap_allocator");
        end else begin
            $display("FAIL page_bitmap_allocator");
        end
        $finish;
    end

endmodule
